// ----- rtl/core/bra_pkg.sv -----
// shared types and constants for the best rational approximation block
// no dependencies
`default_nettype none
package bra_pkg;
    typedef enum logic [2:0] {
        S_IDLE, S_GCD, S_DIV, S_CHECK, S_DIV2, S_FLOOR, S_CEIL, S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic gcd_step;
        logic div_start;
        logic div_step;
        logic div_take;
        logic div2_start;
        logic take_reduced;
        logic loop_init;
        logic try_floor;
        logic try_ceil;
        logic b_inc;
        logic sat;
    } t_cmd;

    typedef struct packed {
        logic y_zero;
        logic gcd_done;
        logic div_done;
        logic lim_ge_y;
        logic b_gt_lim;
    } t_stat;
endpackage
`default_nettype wire

// ----- rtl/core/bra_ctrl.sv -----
// controller for the best rational approximation block
// uses bra_pkg
`default_nettype none
module bra_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic          i_out_stall,
    input  wire bra_pkg::t_stat i_stat,
    output logic               o_stall,
    output logic               o_valid,
    output bra_pkg::t_cmd      o_cmd
);
    bra_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= bra_pkg::S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        o_valid = 1'b0;
        unique case (r_state)
            bra_pkg::S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = bra_pkg::S_GCD;
                end
            end
            bra_pkg::S_GCD: begin
                if (i_stat.y_zero) begin
                    o_cmd.sat = 1'b1;
                    n_state = bra_pkg::S_OUT;
                end else if (i_stat.gcd_done) begin
                    o_cmd.div_start = 1'b1;
                    n_state = bra_pkg::S_DIV;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            bra_pkg::S_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.div_take = 1'b1;
                    n_state = bra_pkg::S_CHECK;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            bra_pkg::S_CHECK: begin
                if (i_stat.lim_ge_y) begin
                    o_cmd.take_reduced = 1'b1;
                    n_state = bra_pkg::S_OUT;
                end else begin
                    o_cmd.div2_start = 1'b1;
                    n_state = bra_pkg::S_DIV2;
                end
            end
            bra_pkg::S_DIV2: begin
                if (i_stat.div_done) begin
                    o_cmd.loop_init = 1'b1;
                    n_state = bra_pkg::S_FLOOR;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            bra_pkg::S_FLOOR: begin
                if (i_stat.b_gt_lim) begin
                    n_state = bra_pkg::S_OUT;
                end else begin
                    o_cmd.try_floor = 1'b1;
                    n_state = bra_pkg::S_CEIL;
                end
            end
            bra_pkg::S_CEIL: begin
                o_cmd.try_ceil = 1'b1;
                o_cmd.b_inc = 1'b1;
                n_state = bra_pkg::S_FLOOR;
            end
            bra_pkg::S_OUT: begin
                o_valid = 1'b1;
                if (!i_out_stall) n_state = bra_pkg::S_IDLE;
            end
            default: n_state = bra_pkg::S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ----- rtl/core/bra_dp.sv -----
// datapath: binary gcd, restoring dividers, candidate tracking
// uses bra_pkg
`default_nettype none
module bra_dp #(
    parameter int VALUE_BITS = 20
) (
    input  wire logic                  i_clk,
    input  wire bra_pkg::t_cmd         i_cmd,
    input  wire logic [VALUE_BITS-1:0] i_numerator,
    input  wire logic [VALUE_BITS-1:0] i_denominator,
    input  wire logic [VALUE_BITS-1:0] i_max_denominator,
    output bra_pkg::t_stat             o_stat,
    output logic [VALUE_BITS-1:0]      o_best_numerator,
    output logic [VALUE_BITS-1:0]      o_best_denominator
);
    localparam int W = VALUE_BITS;
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_xn, r_yd, r_lim, r_ga, r_gb;
    logic [CW-1:0] r_sh;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_dv, r_d0, r_d1, r_r0, r_r1;
    logic [W-1:0]  r_x, r_y;
    logic [W-1:0]  r_b, r_fl, r_rem;
    logic [W-1:0]  r_bp, r_bb, r_be;
    logic          r_have;

    // two divider lanes share one divisor: first xn/g and yd/g, then lane 0
    // alone gives x/y so floor and remainder of b*x/y step by one add per b
    logic [W-1:0]   g;
    logic [W:0]     t0, t1;
    logic [W-1:0]   sub0, sub1;
    logic [W:0]     radd;
    logic [W-1:0]   erc;
    logic [2*W-1:0] lhs_f, rhs_f, lhs_c;

    assign g = r_gb << r_sh;
    assign t0 = {r_r0, r_d0[W-1]};
    assign t1 = {r_r1, r_d1[W-1]};
    assign sub0 = t0[W-1:0] - r_dv;
    assign sub1 = t1[W-1:0] - r_dv;
    // r_r0 holds x mod y once the walk runs, r_d0 holds x div y
    assign radd = {1'b0, r_rem} + {1'b0, r_r0};
    assign erc = r_y - r_rem;
    assign lhs_f = {{W{1'b0}}, r_rem} * {{W{1'b0}}, r_bb};
    assign rhs_f = {{W{1'b0}}, r_be} * {{W{1'b0}}, r_b};
    assign lhs_c = {{W{1'b0}}, erc} * {{W{1'b0}}, r_bb};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_xn <= i_numerator;
            r_yd <= i_denominator;
            r_lim <= i_max_denominator;
            r_ga <= i_numerator;
            r_gb <= i_denominator;
            r_sh <= '0;
        end
        if (i_cmd.gcd_step) begin
            // stein's algorithm, one step a cycle, ends when a reaches zero
            if (!r_ga[0] && !r_gb[0]) begin
                r_ga <= r_ga >> 1;
                r_gb <= r_gb >> 1;
                r_sh <= r_sh + CW'(1);
            end else if (!r_ga[0]) begin
                r_ga <= r_ga >> 1;
            end else if (!r_gb[0]) begin
                r_gb <= r_gb >> 1;
            end else if (r_ga >= r_gb) begin
                r_ga <= r_ga - r_gb;
            end else begin
                r_gb <= r_gb - r_ga;
            end
        end
        if (i_cmd.div_start) begin
            r_d0 <= r_xn;
            r_d1 <= r_yd;
            r_dv <= g;
            r_r0 <= '0;
            r_r1 <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_cnt <= r_cnt + CW'(1);
            if (t0 >= {1'b0, r_dv}) begin
                r_r0 <= sub0;
                r_d0 <= {r_d0[W-2:0], 1'b1};
            end else begin
                r_r0 <= t0[W-1:0];
                r_d0 <= {r_d0[W-2:0], 1'b0};
            end
            if (t1 >= {1'b0, r_dv}) begin
                r_r1 <= sub1;
                r_d1 <= {r_d1[W-2:0], 1'b1};
            end else begin
                r_r1 <= t1[W-1:0];
                r_d1 <= {r_d1[W-2:0], 1'b0};
            end
        end
        if (i_cmd.div_take) begin
            r_x <= r_d0;
            r_y <= r_d1;
        end
        if (i_cmd.div2_start) begin
            r_d0 <= r_x;
            r_dv <= r_y;
            r_r0 <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.loop_init) begin
            // b=1: floor and remainder of x/y straight from the divider
            r_b <= W'(1);
            r_fl <= r_d0;
            r_rem <= r_r0;
            r_have <= 1'b0;
            r_bp <= W'(1);
            r_bb <= W'(1);
            r_be <= '0;
        end
        if (i_cmd.try_floor) begin
            if (!r_have || lhs_f < rhs_f) begin
                r_bp <= r_fl;
                r_bb <= r_b;
                r_be <= r_rem;
                r_have <= 1'b1;
            end
        end
        if (i_cmd.try_ceil) begin
            if (lhs_c < rhs_f) begin
                r_bp <= r_fl + W'(1);
                r_bb <= r_b;
                r_be <= erc;
            end
        end
        if (i_cmd.b_inc) begin
            // remainder stays below y, so at most one carry into the floor
            r_b <= r_b + W'(1);
            if (radd >= {1'b0, r_y}) begin
                r_rem <= radd[W-1:0] - r_y;
                r_fl <= r_fl + r_d0 + W'(1);
            end else begin
                r_rem <= radd[W-1:0];
                r_fl <= r_fl + r_d0;
            end
        end
        if (i_cmd.take_reduced) begin
            r_bp <= r_x;
            r_bb <= r_y;
        end
        if (i_cmd.sat) begin
            r_bp <= '1;
            r_bb <= W'(1);
        end
    end

    assign o_stat.y_zero = (r_yd == '0);
    assign o_stat.gcd_done = (r_ga == '0);
    assign o_stat.div_done = (r_cnt == CW'(W));
    assign o_stat.lim_ge_y = (r_lim >= r_y);
    assign o_stat.b_gt_lim = (r_b > r_lim);

    assign o_best_numerator = r_bp;
    assign o_best_denominator = r_bb;
endmodule
`default_nettype wire

// ----- rtl/core/best_rational_approximation.sv -----
// top level of the best rational approximation block
// uses bra_pkg, bra_ctrl, bra_dp
`default_nettype none
// One word in, one word out. A query reduces numerator/denominator with a
// one-step-a-cycle binary gcd and divides both by the gcd in a pair of
// restoring dividers. If the bound reaches the reduced denominator the
// reduced fraction comes back. Otherwise the reduced numerator is divided by
// the reduced denominator once more, so floor and remainder of b*x/y step by
// one add, and every denominator b from 1 to the bound is tried, floor then
// ceiling, errors compared by cross-multiplication; ties keep the earlier
// candidate. A zero denominator answers all ones over 1, a zero bound
// answers 1/1. Input stall is high from acceptance until the result word is
// taken, so one query is in flight.
module best_rational_approximation #(
    parameter int VALUE_BITS = 20
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [VALUE_BITS-1:0] i_numerator,
    input  wire logic [VALUE_BITS-1:0] i_denominator,
    input  wire logic [VALUE_BITS-1:0] i_max_denominator,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [VALUE_BITS-1:0]      o_best_numerator,
    output logic [VALUE_BITS-1:0]      o_best_denominator
);
    bra_pkg::t_cmd  cmd;
    bra_pkg::t_stat stat;

    bra_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid),
        .i_out_stall(i_stall), .i_stat(stat), .o_stall(o_stall),
        .o_valid(o_valid), .o_cmd(cmd)
    );

    bra_dp #(.VALUE_BITS(VALUE_BITS)) u_dp (
        .i_clk(i_clk), .i_cmd(cmd), .i_numerator(i_numerator),
        .i_denominator(i_denominator), .i_max_denominator(i_max_denominator),
        .o_stat(stat), .o_best_numerator(o_best_numerator),
        .o_best_denominator(o_best_denominator)
    );
endmodule
`default_nettype wire
